>>> hw/rtl/apl_pkg.sv
package apl_pkg;

    localparam int CAPACITY = 128;

    localparam int KIND_W  = 2;
    localparam int POS_W   = 8;
    localparam int VAL_W   = 32;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 8;

    localparam int ADDR_W  = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;

    // stream payload widths, rounded up to whole bytes
    localparam int S_DATA_W = ((POS_W + VAL_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((STAT_W + VAL_W + LEN_W + 7) / 8) * 8;

    localparam logic [KIND_W-1:0] KIND_READ   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic load;
        logic shift_up;
        logic shift_dn;
        logic put_val;
        logic emit;
    } ctl_cmd_t;

    typedef struct packed {
        logic op_read;
        logic op_insert;
        logic op_delete;
        logic shift_done;
        logic out_busy;
    } ctl_stat_t;

endpackage

>>> hw/rtl/positional_array_list.sv
// Ordered list of signed 32-bit values kept in a single memory of
// apl_pkg::CAPACITY entries. Each request beat on the slave side carries a
// kind in s_tuser (read, insert, delete) and a position and value in s_tdata;
// each one yields exactly one result beat on the master side with a status
// (success, position out of range, list full), the value read (zero unless a
// read succeeded) and the list length after the request. The block works on
// one request at a time; a request is taken only while the controller is
// idle, but the finished result sits in its own output register, so the next
// request is accepted while that beat still waits for m_tready. Timing is set
// by the element shift through the memory, one element per cycle with the
// read of one entry overlapping the write of the previous one, and the shift
// ends once the last write has landed. A rejected request goes straight to
// the result, a read passes through one read state, and an insert writes the
// new value after its shift. No clearing pass runs after reset; entries at or
// beyond the current length are never read.
module positional_array_list (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: position [7:0], item_value [39:8]
    input  logic [apl_pkg::S_DATA_W-1:0]    s_tdata,
    // s_tuser: req_type [1:0]
    input  logic [apl_pkg::KIND_W-1:0]      s_tuser,

    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: status [1:0], read_value [33:2], list_len [41:34], zero pad
    output logic [apl_pkg::M_DATA_W-1:0]    m_tdata
);

    // command and status between the sequencer and the datapath
    apl_pkg::ctl_cmd_t  cmd;
    apl_pkg::ctl_stat_t stat;

    // Sequencer: decides the request path at accept time, steps the shift
    // until the datapath reports it drained, then hands the result over.
    apl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Datapath: range and capacity checks, element count, shift pointer,
    // element memory and the output register.
    apl_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .stat     (stat)
    );

endmodule

>>> hw/rtl/apl_ram.sv
module apl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/apl_ctrl.sv
module apl_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  apl_pkg::ctl_stat_t stat,
    output apl_pkg::ctl_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_READ = 3'd1;
    localparam logic [2:0] S_UP   = 3'd2;
    localparam logic [2:0] S_PUT  = 3'd3;
    localparam logic [2:0] S_DN   = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.load     = accept;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (stat.op_read)
                        state_next = S_READ;
                    else if (stat.op_insert)
                        state_next = S_UP;
                    else if (stat.op_delete)
                        state_next = S_DN;
                    else
                        state_next = S_DONE;
                end
            end
            S_READ:
            begin
                state_next = S_DONE;
            end
            S_UP:
            begin
                cmd.shift_up = 1'b1;
                if (stat.shift_done)
                    state_next = S_PUT;
            end
            S_PUT:
            begin
                cmd.put_val = 1'b1;
                state_next  = S_DONE;
            end
            S_DN:
            begin
                cmd.shift_dn = 1'b1;
                if (stat.shift_done)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

endmodule

>>> hw/rtl/apl_dpath.sv
module apl_dpath (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [apl_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic [apl_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [apl_pkg::M_DATA_W-1:0]    m_tdata,
    input  apl_pkg::ctl_cmd_t               cmd,
    output apl_pkg::ctl_stat_t              stat
);

    localparam int AW  = apl_pkg::ADDR_W;
    localparam int CW  = apl_pkg::CNT_W;
    localparam int VW  = apl_pkg::VAL_W;
    localparam int LW  = apl_pkg::LEN_W;
    localparam int PW  = apl_pkg::POS_W;
    localparam int SW  = apl_pkg::STAT_W;
    localparam int MW  = apl_pkg::M_DATA_W;

    // incoming request fields
    logic [PW-1:0]              in_pos;
    logic [VW-1:0]              in_val;
    logic [apl_pkg::CMP_W-1:0]  pos_ext;
    logic [apl_pkg::CMP_W-1:0]  cnt_ext;
    logic                       is_read;
    logic                       is_ins;
    logic                       is_del;
    logic                       rd_ok;
    logic                       ins_ok;
    logic                       del_ok;
    logic                       ins_full;
    logic [SW-1:0]              status_next;

    // request held while it runs
    logic [CW-1:0]  pos_reg;
    logic [VW-1:0]  val_reg;
    logic [SW-1:0]  status_reg;
    logic           rd_reg;
    logic           ins_reg;
    logic           del_reg;

    // element count and shift engine
    logic [CW-1:0]  cnt_reg;
    logic [CW-1:0]  cnt_after;
    logic [CW-1:0]  ptr_reg;
    logic [CW-1:0]  ptr_next;
    logic           pend_reg;
    logic [AW-1:0]  wr_addr_reg;
    logic [AW-1:0]  wr_addr_next;
    logic           up_more;
    logic           dn_more;
    logic           issue;
    logic [CW-1:0]  ptr_dec;

    // memory port
    logic           ram_we;
    logic [AW-1:0]  ram_waddr;
    logic [VW-1:0]  ram_wdata;
    logic [AW-1:0]  ram_raddr;
    logic [VW-1:0]  ram_rdata;

    // output register
    logic                   m_valid_reg;
    logic [MW-1:0]          m_data_reg;
    logic [LW+CW-1:0]       len_wide;
    logic [VW-1:0]          rd_value;

    assign in_pos  = s_tdata[PW-1:0];
    assign in_val  = s_tdata[PW+VW-1:PW];
    assign pos_ext = apl_pkg::CMP_W'(in_pos);
    assign cnt_ext = apl_pkg::CMP_W'(cnt_reg);

    assign is_read  = (s_tuser == apl_pkg::KIND_READ);
    assign is_ins   = (s_tuser == apl_pkg::KIND_INSERT);
    assign is_del   = (s_tuser == apl_pkg::KIND_DELETE);
    assign ins_full = (cnt_reg == CW'(apl_pkg::CAPACITY));
    assign rd_ok    = is_read && (pos_ext < cnt_ext);
    assign ins_ok   = is_ins && (pos_ext <= cnt_ext) && !ins_full;
    assign del_ok   = is_del && (pos_ext < cnt_ext);

    always_comb
    begin
        if (rd_ok || ins_ok || del_ok)
            status_next = apl_pkg::ST_OK;
        else if (is_ins && (pos_ext <= cnt_ext))
            status_next = apl_pkg::ST_FULL;
        else
            status_next = apl_pkg::ST_RANGE;
    end

    assign stat.op_read   = rd_ok;
    assign stat.op_insert = ins_ok;
    assign stat.op_delete = del_ok;

    // Insert walks the pointer down from the old length to the position;
    // delete walks it up from position plus one to the length.
    assign up_more = (ptr_reg > pos_reg);
    assign dn_more = (ptr_reg < cnt_reg);
    assign issue   = (cmd.shift_up && up_more) || (cmd.shift_dn && dn_more);
    assign ptr_dec = ptr_reg - CW'(1);

    assign stat.shift_done = !pend_reg && !(ins_reg ? up_more : dn_more);
    assign stat.out_busy   = m_valid_reg && !m_tready;

    always_comb
    begin
        ptr_next     = ptr_reg;
        wr_addr_next = wr_addr_reg;
        if (cmd.load)
        begin
            ptr_next = ins_ok ? cnt_reg : (pos_ext[CW-1:0] + CW'(1));
        end
        else if (issue)
        begin
            if (cmd.shift_up)
            begin
                ptr_next     = ptr_dec;
                wr_addr_next = ptr_reg[AW-1:0];
            end
            else
            begin
                ptr_next     = ptr_reg + CW'(1);
                wr_addr_next = ptr_dec[AW-1:0];
            end
        end
    end

    always_comb
    begin
        if (cmd.shift_up)
            ram_raddr = ptr_dec[AW-1:0];
        else if (cmd.shift_dn)
            ram_raddr = ptr_reg[AW-1:0];
        else
            ram_raddr = pos_reg[AW-1:0];
    end

    assign ram_we    = pend_reg || cmd.put_val;
    assign ram_waddr = cmd.put_val ? pos_reg[AW-1:0] : wr_addr_reg;
    assign ram_wdata = cmd.put_val ? val_reg : ram_rdata;

    apl_ram #(
        .WIDTH (VW),
        .DEPTH (apl_pkg::CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        cnt_after = cnt_reg;
        if (ins_reg)
            cnt_after = cnt_reg + CW'(1);
        else if (del_reg)
            cnt_after = cnt_reg - CW'(1);
    end

    assign len_wide = {{LW{1'b0}}, cnt_after};
    assign rd_value = rd_reg ? ram_rdata : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg     <= '0;
            ptr_reg     <= '0;
            pend_reg    <= 1'b0;
            rd_reg      <= 1'b0;
            ins_reg     <= 1'b0;
            del_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            pend_reg <= issue;
            if (cmd.load)
            begin
                rd_reg  <= rd_ok;
                ins_reg <= ins_ok;
                del_reg <= del_ok;
            end
            if (cmd.emit)
            begin
                cnt_reg     <= cnt_after;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= wr_addr_next;
        if (cmd.load)
        begin
            pos_reg    <= pos_ext[CW-1:0];
            val_reg    <= in_val;
            status_reg <= status_next;
        end
        if (cmd.emit)
        begin
            m_data_reg <= MW'({len_wide[LW-1:0], rd_value, status_reg});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CW'(apl_pkg::CAPACITY))
        else $error("element count above capacity");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> !(m_valid_reg && !m_tready))
        else $error("result loaded over a waiting beat");

    a_pend_src: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(cmd.shift_up || cmd.shift_dn))
        else $error("shift write without a shift read");

    a_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.shift_up || cmd.shift_dn) |-> (ptr_reg <= cnt_reg))
        else $error("shift pointer past list end");

endmodule

>>> test/positional_array_list_tb.sv
`timescale 1ns / 1ps

module positional_array_list_tb;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_ITEMS = 700;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int DRAIN_CYCLES = 140;   // longest insert shift plus margin
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int SCRIPT_ROWS  = 26;

    // req_type 3 has no meaning in the block and must be rejected
    localparam logic [apl_pkg::KIND_W-1:0] KIND_UNKNOWN = 2'd3;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           s_tvalid;
    logic                           s_tready;
    // position [7:0], item_value [39:8]
    logic [apl_pkg::S_DATA_W-1:0]   s_tdata;
    // req_type [1:0]
    logic [apl_pkg::KIND_W-1:0]     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    // status [1:0], read_value [33:2], list_len [41:34]
    logic [apl_pkg::M_DATA_W-1:0]   m_tdata;

    typedef struct packed {
        logic [apl_pkg::STAT_W-1:0] status;
        logic [apl_pkg::VAL_W-1:0]  read_value;
        logic [apl_pkg::LEN_W-1:0]  list_len;
    } outcome_t;

    // One directed request. When fill is set, the list is first topped up to
    // CAPACITY with random inserts. When typed is set, the w_* fields are the
    // result to expect; otherwise the shadow list decides it.
    typedef struct packed {
        logic                       fill;
        logic [apl_pkg::KIND_W-1:0] kind;
        logic [apl_pkg::POS_W-1:0]  pos;
        logic [apl_pkg::VAL_W-1:0]  value;
        logic                       typed;
        logic [apl_pkg::STAT_W-1:0] w_status;
        logic [apl_pkg::VAL_W-1:0]  w_value;
        logic [apl_pkg::LEN_W-1:0]  w_len;
    } script_row_t;

    script_row_t script [SCRIPT_ROWS] = '{
        // empty list: reads, deletes and an insert past the end are out of range
        '{1'b0, apl_pkg::KIND_READ, 8'd0, 32'h0000_0000, 1'b1, apl_pkg::ST_RANGE, 32'h0, 8'd0},
        '{1'b0, apl_pkg::KIND_DELETE, 8'd0, 32'h0000_0000, 1'b1, apl_pkg::ST_RANGE, 32'h0, 8'd0},
        '{1'b0, apl_pkg::KIND_INSERT, 8'd1, 32'h1234_5678, 1'b1, apl_pkg::ST_RANGE, 32'h0, 8'd0},
        // build a short list from the value extremes
        '{1'b0, apl_pkg::KIND_INSERT, 8'd0, 32'h7FFF_FFFF, 1'b1, apl_pkg::ST_OK, 32'h0, 8'd1},
        '{1'b0, apl_pkg::KIND_INSERT, 8'd0, 32'h8000_0000, 1'b1, apl_pkg::ST_OK, 32'h0, 8'd2},
        '{1'b0, apl_pkg::KIND_READ, 8'd0, 32'h0000_0000, 1'b1, apl_pkg::ST_OK,
          32'h8000_0000, 8'd2},
        '{1'b0, apl_pkg::KIND_READ, 8'd1, 32'hFFFF_FFFF, 1'b1, apl_pkg::ST_OK,
          32'h7FFF_FFFF, 8'd2},
        '{1'b0, apl_pkg::KIND_READ, 8'd2, 32'h0000_0000, 1'b1, apl_pkg::ST_RANGE, 32'h0, 8'd2},
        '{1'b0, apl_pkg::KIND_INSERT, 8'd2, 32'h0000_0000, 1'b1, apl_pkg::ST_OK, 32'h0, 8'd3},
        '{1'b0, apl_pkg::KIND_INSERT, 8'd1, 32'hFFFF_FFFF, 1'b1, apl_pkg::ST_OK, 32'h0, 8'd4},
        // rejects: unknown kind and positions past the end
        '{1'b0, KIND_UNKNOWN, 8'd0, 32'hA5A5_A5A5, 1'b1, apl_pkg::ST_RANGE, 32'h0, 8'd4},
        '{1'b0, apl_pkg::KIND_READ, 8'd255, 32'h0000_0000, 1'b1, apl_pkg::ST_RANGE, 32'h0, 8'd4},
        '{1'b0, apl_pkg::KIND_INSERT, 8'd255, 32'h5A5A_5A5A, 1'b1, apl_pkg::ST_RANGE,
          32'h0, 8'd4},
        '{1'b0, apl_pkg::KIND_DELETE, 8'd255, 32'h0000_0000, 1'b1, apl_pkg::ST_RANGE,
          32'h0, 8'd4},
        '{1'b0, apl_pkg::KIND_DELETE, 8'd4, 32'h0000_0000, 1'b1, apl_pkg::ST_RANGE, 32'h0, 8'd4},
        // deletes in the middle and at the tail
        '{1'b0, apl_pkg::KIND_DELETE, 8'd1, 32'h0000_0000, 1'b0, apl_pkg::ST_OK, 32'h0, 8'd0},
        '{1'b0, apl_pkg::KIND_READ, 8'd1, 32'h0000_0000, 1'b0, apl_pkg::ST_OK, 32'h0, 8'd0},
        '{1'b0, apl_pkg::KIND_DELETE, 8'd2, 32'h0000_0000, 1'b0, apl_pkg::ST_OK, 32'h0, 8'd0},
        // full list: range check wins over the full check
        '{1'b1, apl_pkg::KIND_INSERT, 8'd128, 32'h0000_0000, 1'b1, apl_pkg::ST_FULL,
          32'h0, 8'd128},
        '{1'b0, apl_pkg::KIND_INSERT, 8'd129, 32'h0000_0000, 1'b1, apl_pkg::ST_RANGE,
          32'h0, 8'd128},
        '{1'b0, apl_pkg::KIND_INSERT, 8'd0, 32'h0000_0055, 1'b1, apl_pkg::ST_FULL,
          32'h0, 8'd128},
        '{1'b0, apl_pkg::KIND_READ, 8'd127, 32'h0000_0000, 1'b0, apl_pkg::ST_OK, 32'h0, 8'd0},
        '{1'b0, apl_pkg::KIND_READ, 8'd128, 32'h0000_0000, 1'b1, apl_pkg::ST_RANGE,
          32'h0, 8'd128},
        // longest shifts in both directions, then a delete of the last element
        '{1'b0, apl_pkg::KIND_DELETE, 8'd0, 32'h0000_0000, 1'b0, apl_pkg::ST_OK, 32'h0, 8'd0},
        '{1'b0, apl_pkg::KIND_INSERT, 8'd0, 32'hFFFF_FFFE, 1'b0, apl_pkg::ST_OK, 32'h0, 8'd0},
        '{1'b0, apl_pkg::KIND_DELETE, 8'd127, 32'h0000_0000, 1'b0, apl_pkg::ST_OK, 32'h0, 8'd0}
    };

    // shadow copy of the list, updated as each request beat is accepted
    logic [apl_pkg::VAL_W-1:0] shadow_list [apl_pkg::CAPACITY];
    int                        shadow_len;

    outcome_t awaited_outcomes [$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       tx_steady = 1'b0;   // sender offers back to back
    bit       rx_hold = 1'b0;     // ask the receiver for one long hold-off

    positional_array_list dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #HALF_PERIOD clk = ~clk;

    // Apply one request to the shadow list and return the result it gives.
    function automatic outcome_t apply_request(input logic [apl_pkg::KIND_W-1:0] kind,
                                               input logic [apl_pkg::POS_W-1:0] pos,
                                               input logic [apl_pkg::VAL_W-1:0] val);
        outcome_t res;
        int       p;
        int       i;
        res.status     = apl_pkg::ST_RANGE;
        res.read_value = '0;
        p = int'(pos);
        case (kind)
            apl_pkg::KIND_READ:
                if (p < shadow_len)
                begin
                    res.read_value = shadow_list[p];
                    res.status     = apl_pkg::ST_OK;
                end
            apl_pkg::KIND_INSERT:
                if (p > shadow_len)
                    res.status = apl_pkg::ST_RANGE;
                else if (shadow_len >= apl_pkg::CAPACITY)
                    res.status = apl_pkg::ST_FULL;
                else
                begin
                    for (i = shadow_len; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = val;
                    shadow_len++;
                    res.status = apl_pkg::ST_OK;
                end
            apl_pkg::KIND_DELETE:
                if (p < shadow_len)
                begin
                    for (i = p; i + 1 < shadow_len; i++)
                        shadow_list[i] = shadow_list[i+1];
                    shadow_len--;
                    res.status = apl_pkg::ST_OK;
                end
            default: ;
        endcase
        res.list_len = apl_pkg::LEN_W'(shadow_len);
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    // Offer one request beat. Valid stays high from the previous beat when no
    // gap is drawn, so back-to-back beats never toggle it within one step.
    task automatic offer(input logic [apl_pkg::KIND_W-1:0] kind,
                         input logic [apl_pkg::POS_W-1:0] pos,
                         input logic [apl_pkg::VAL_W-1:0] val, input logic typed,
                         input outcome_t want);
        int       gap;
        outcome_t pred;
        @(negedge clk);
        gap = tx_steady ? 0 : $urandom_range(0, 8);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= apl_pkg::S_DATA_W'({val, pos});
        do @(posedge clk); while (!s_tready);
        pred = apply_request(kind, pos, val);
        awaited_outcomes.push_back(typed ? want : pred);
    endtask

    // Receiver: random stalls per beat, runs of none, and one long hold-off
    // on request so the block backs up into its input.
    initial
    begin : result_sink
        int gap;
        int beats;
        bit rx_steady;
        beats = 0;
        rx_steady = 1'b0;
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (rx_hold)
            begin
                rx_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                if (beats % 40 == 0)
                    rx_steady = ($urandom_range(0, 3) == 0);
                gap = rx_steady ? 0 : $urandom_range(0, 8);
                if (gap != 0)
                begin
                    m_tready <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            beats++;
        end
    end

    // Check every result beat against the oldest outstanding expectation.
    always @(posedge clk)
    begin : result_check
        outcome_t got;
        outcome_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status     = m_tdata[1:0];
            got.read_value = m_tdata[33:2];
            got.list_len   = m_tdata[41:34];
            if (awaited_outcomes.size() == 0)
                report_mismatch($sformatf("result beat with nothing outstanding: %h",
                                          m_tdata));
            else
            begin
                exp = awaited_outcomes.pop_front();
                if (got.status !== exp.status)
                    report_mismatch($sformatf("status got %0d want %0d",
                                              got.status, exp.status));
                if (got.read_value !== exp.read_value)
                    report_mismatch($sformatf("read_value got %h want %h",
                                              got.read_value, exp.read_value));
                if (got.list_len !== exp.list_len)
                    report_mismatch($sformatf("list_len got %0d want %0d",
                                              got.list_len, exp.list_len));
            end
        end
    end

    // Watchdog: far beyond the slowest legal run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int                         r;
        int                         n;
        int                         sel;
        int                         top;
        int                         ins_pct;
        int                         del_pct;
        bit                         growing;
        logic [apl_pkg::KIND_W-1:0] kind;
        logic [apl_pkg::POS_W-1:0]  pos;
        logic [apl_pkg::VAL_W-1:0]  val;
        outcome_t                   want;

        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = apl_pkg::KIND_READ;
        shadow_len = 0;
        growing  = 1'b1;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: walk the script, topping the list up where asked.
        for (r = 0; r < SCRIPT_ROWS; r++)
        begin
            if (script[r].fill)
                while (shadow_len < apl_pkg::CAPACITY)
                    offer(apl_pkg::KIND_INSERT,
                          apl_pkg::POS_W'($urandom_range(0, shadow_len)), $urandom,
                          1'b0, '0);
            want.status     = script[r].w_status;
            want.read_value = script[r].w_value;
            want.list_len   = script[r].w_len;
            offer(script[r].kind, script[r].pos, script[r].value, script[r].typed, want);
        end

        // Random part: the list drifts between empty and full, with positions
        // biased to the ends and a small share of noise requests.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 50 == 0)
                tx_steady = ($urandom_range(0, 3) == 0);
            if (n == 200)
                rx_hold = 1'b1;
            if (n == 500)
            begin
                // drop valid and let every outstanding result come back
                @(negedge clk);
                s_tvalid <= 1'b0;
                while (awaited_outcomes.size() != 0) @(posedge clk);
            end

            if (shadow_len == apl_pkg::CAPACITY && $urandom_range(0, 4) == 0)
                growing = 1'b0;
            else if (shadow_len == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 79) == 0)
                growing = !growing;

            case ($urandom_range(0, 7))
                0: val = 32'h8000_0000;
                1: val = 32'h7FFF_FFFF;
                2: val = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
                default: val = $urandom;
            endcase

            if ($urandom_range(0, 99) < 6)
            begin
                kind = apl_pkg::KIND_W'($urandom_range(0, 3));
                pos  = apl_pkg::POS_W'($urandom_range(0, 255));
            end
            else
            begin
                ins_pct = growing ? 60 : 20;
                del_pct = growing ? 20 : 60;
                sel = $urandom_range(0, 99);
                if (sel < ins_pct)
                    kind = apl_pkg::KIND_INSERT;
                else if (sel < ins_pct + del_pct)
                    kind = apl_pkg::KIND_DELETE;
                else
                    kind = apl_pkg::KIND_READ;
                top = (kind == apl_pkg::KIND_INSERT) ? shadow_len : shadow_len - 1;
                if (top < 0)
                    pos = apl_pkg::POS_W'($urandom_range(0, 255));
                else
                    case ($urandom_range(0, 4))
                        0: pos = '0;
                        1: pos = apl_pkg::POS_W'(top);
                        default: pos = apl_pkg::POS_W'($urandom_range(0, top));
                    endcase
            end
            offer(kind, pos, val, 1'b0, '0);
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain, then give the block time to show any stray beat
        while (awaited_outcomes.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
